// ===== rtl/key_change_event_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// key_change_event_queue_unit_macros
// Assertion macros used by the key change event queue unit.
// ----------------------------------------------------------------------------
`ifndef KEY_CHANGE_EVENT_QUEUE_UNIT_MACROS_SVH
`define KEY_CHANGE_EVENT_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define KCEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kceq assertion failed");

// next-cycle implication
`define KCEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kceq assertion failed");

`endif

// ===== rtl/kceq_pkg.sv =====
// ----------------------------------------------------------------------------
// kceq_pkg
// Types, codes and sizes of the key change event queue.
// ----------------------------------------------------------------------------
package kceq_pkg;

    localparam int KEY_COUNT_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int MAP_W     = 16;
    localparam int MAP_IDX_W = 4;
    localparam int KEY_W     = 10;
    localparam int HCNT_W    = 11;

    localparam logic [2:0] MODE_KEY_EVENT    = 3'd0;
    localparam logic [2:0] MODE_SYNTHESIZE   = 3'd1;
    localparam logic [2:0] MODE_POP          = 3'd2;
    localparam logic [2:0] MODE_LIST_HELD    = 3'd3;
    localparam logic [2:0] MODE_CLEAR_EVENTS = 3'd4;
    localparam logic [2:0] MODE_RESET_ALL    = 3'd5;
    localparam logic [2:0] MODE_FOCUS_LOST   = 3'd6;

    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_POPPED    = 3'd1;
    localparam logic [2:0] KIND_EMPTY     = 3'd2;
    localparam logic [2:0] KIND_HELD_CODE = 3'd3;
    localparam logic [2:0] KIND_HELD_CNT  = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] key_code;
        logic        press;
        logic [5:0]  limit;
    } in_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  out_key;
        logic              out_pressed;
        logic [HCNT_W-1:0] held_count;
        logic              dropped;
        logic              pending;
        logic              wake;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pressed;
    } event_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } map_ctl_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } fifo_sts_t;

endpackage

// ===== rtl/key_change_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// key_change_event_queue_unit
// Held-key bitmap, key change event FIFO and wake flag.
//
// Input channel in_valid/in_stall/in_data carries one command beat; output
// channel out_valid/out_stall/out_data returns result beats, the final one of
// each command marked by last. cfg_write/cfg_data writes enable; writing zero
// flushes the queue and clears wake.
// One command is worked at a time; in_stall is high until its last result
// beat sits in the output register, which then waits for the receiver while
// the next command is taken in.
// Key events and pops pass through a memory read, a read-modify-write or
// pointer update, then the result. Out-of-range keys, flushes and unused
// modes go straight to the result. list_held reads the ceil(KEY_COUNT/16)
// bitmap rows of 16 keys in turn (64 rows at 1024 keys) through the single
// bitmap read port and emits one beat per listed code.
// A stalled receiver holds the output beat and pauses the bitmap walk.
// Reset clears the bitmap through per-row valid bits, the queue, wake and
// enable at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "key_change_event_queue_unit_macros.svh"

module key_change_event_queue_unit #(
    parameter int KEY_COUNT   = kceq_pkg::KEY_COUNT_DEF,
    parameter int QUEUE_DEPTH = kceq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  kceq_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output kceq_pkg::out_t  out_data
);

    localparam int ROWS  = (KEY_COUNT + kceq_pkg::MAP_W - 1) / kceq_pkg::MAP_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(KEY_COUNT + 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [16:0]      KEY_LIM  = 17'(KEY_COUNT);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_KEY_UPD   = 6'b000010,
        ST_POP       = 6'b000100,
        ST_LIST_LOAD = 6'b001000,
        ST_LIST_BITS = 6'b010000,
        ST_EMIT      = 6'b100000
    } state_t;

    function automatic logic [4:0] popcount16(input logic [kceq_pkg::MAP_W-1:0] w);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < kceq_pkg::MAP_W; i++)
        begin
            n = n + 5'(w[i]);
        end
        return n;
    endfunction

    function automatic logic [kceq_pkg::MAP_IDX_W-1:0] lowest16(
        input logic [kceq_pkg::MAP_W-1:0] w);
        logic [kceq_pkg::MAP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = kceq_pkg::MAP_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = kceq_pkg::MAP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    state_t                       state_reg, state_next;
    kceq_pkg::in_t                in_reg, in_next;
    logic                         enable_reg, enable_next;
    logic                         wake_reg, wake_next;
    logic [2:0]                   res_kind_reg, res_kind_next;
    logic [kceq_pkg::KEY_W-1:0]   res_key_reg, res_key_next;
    logic                         res_pressed_reg, res_pressed_next;
    logic                         res_dropped_reg, res_dropped_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [kceq_pkg::MAP_W-1:0]   word_reg, word_next;
    logic [5:0]                   emitted_reg, emitted_next;
    kceq_pkg::out_t               out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    kceq_pkg::map_ctl_t           map_ctl;
    logic [ROW_W-1:0]             map_rd_row;
    logic [kceq_pkg::MAP_W-1:0]   map_wr_data;
    logic [kceq_pkg::MAP_W-1:0]   map_rd_data;
    kceq_pkg::fifo_ctl_t          fifo_ctl;
    kceq_pkg::event_t             fifo_push_data;
    kceq_pkg::event_t             fifo_rd_data;
    kceq_pkg::fifo_sts_t          fifo_sts;

    logic                         out_free;
    logic                         key_in_range;
    logic                         bit_now;
    logic [kceq_pkg::MAP_IDX_W-1:0] low_idx;

    kceq_held_map #(
        .KEY_COUNT (KEY_COUNT)
    ) u_held_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (map_ctl),
        .rd_row  (map_rd_row),
        .wr_row  (in_reg.key_code[ROW_W+kceq_pkg::MAP_IDX_W-1:kceq_pkg::MAP_IDX_W]),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    kceq_event_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_event_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fifo_ctl),
        .push_data (fifo_push_data),
        .rd_data   (fifo_rd_data),
        .sts       (fifo_sts)
    );

    assign out_free     = !out_valid_reg || !out_stall;
    assign key_in_range = ({1'b0, in_data.key_code} < KEY_LIM);
    assign bit_now      = map_rd_data[in_reg.key_code[kceq_pkg::MAP_IDX_W-1:0]];
    assign low_idx      = lowest16(word_reg);

    assign fifo_push_data.key     = in_reg.key_code[kceq_pkg::KEY_W-1:0];
    assign fifo_push_data.pressed = in_reg.press;

    always_comb
    begin
        map_wr_data = map_rd_data;
        map_wr_data[in_reg.key_code[kceq_pkg::MAP_IDX_W-1:0]] = in_reg.press;
    end

    always_comb
    begin
        state_next       = state_reg;
        in_next          = in_reg;
        enable_next      = enable_reg;
        wake_next        = wake_reg;
        res_kind_next    = res_kind_reg;
        res_key_next     = res_key_reg;
        res_pressed_next = res_pressed_reg;
        res_dropped_next = res_dropped_reg;
        count_next       = count_reg;
        row_next         = row_reg;
        word_next        = word_reg;
        emitted_next     = emitted_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && out_stall;
        map_ctl          = '0;
        map_rd_row       = in_data.key_code[ROW_W+kceq_pkg::MAP_IDX_W-1:kceq_pkg::MAP_IDX_W];
        fifo_ctl         = '0;

        if (cfg_write)
        begin
            enable_next = cfg_data;
            if (!cfg_data)
            begin
                fifo_ctl.flush = 1'b1;
                wake_next      = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next          = in_data;
                    res_kind_next    = kceq_pkg::KIND_ACK;
                    res_key_next     = '0;
                    res_pressed_next = 1'b0;
                    res_dropped_next = 1'b0;
                    count_next       = '0;
                    row_next         = '0;
                    emitted_next     = '0;
                    state_next       = ST_EMIT;
                    case (in_data.mode)
                        kceq_pkg::MODE_KEY_EVENT, kceq_pkg::MODE_SYNTHESIZE:
                        begin
                            if (key_in_range)
                            begin
                                map_ctl.rd_en = 1'b1;
                                state_next    = ST_KEY_UPD;
                            end
                        end
                        kceq_pkg::MODE_POP:
                        begin
                            state_next = ST_POP;
                        end
                        kceq_pkg::MODE_LIST_HELD:
                        begin
                            map_ctl.rd_en = 1'b1;
                            map_rd_row    = '0;
                            state_next    = ST_LIST_LOAD;
                        end
                        kceq_pkg::MODE_CLEAR_EVENTS:
                        begin
                            fifo_ctl.flush = 1'b1;
                            wake_next      = 1'b0;
                        end
                        kceq_pkg::MODE_RESET_ALL:
                        begin
                            fifo_ctl.flush  = 1'b1;
                            map_ctl.clr_all = 1'b1;
                            wake_next       = 1'b0;
                        end
                        kceq_pkg::MODE_FOCUS_LOST:
                        begin
                            fifo_ctl.flush  = 1'b1;
                            map_ctl.clr_all = 1'b1;
                            wake_next       = enable_reg;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_KEY_UPD:
            begin
                if (bit_now != in_reg.press)
                begin
                    map_ctl.wr_en = 1'b1;
                    if (in_reg.mode == kceq_pkg::MODE_SYNTHESIZE || enable_reg)
                    begin
                        if (fifo_sts.full)
                        begin
                            res_dropped_next = 1'b1;
                        end
                        else
                        begin
                            fifo_ctl.push = 1'b1;
                            wake_next     = 1'b1;
                        end
                    end
                end
                state_next = ST_EMIT;
            end
            ST_POP:
            begin
                if (fifo_sts.empty)
                begin
                    res_kind_next = kceq_pkg::KIND_EMPTY;
                end
                else
                begin
                    res_kind_next    = kceq_pkg::KIND_POPPED;
                    res_key_next     = fifo_rd_data.key;
                    res_pressed_next = fifo_rd_data.pressed;
                    fifo_ctl.pop     = 1'b1;
                    if (fifo_sts.one)
                    begin
                        wake_next = 1'b0;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_LIST_LOAD:
            begin
                word_next  = map_rd_data;
                count_next = count_reg + CNT_W'(popcount16(map_rd_data));
                state_next = ST_LIST_BITS;
            end
            ST_LIST_BITS:
            begin
                if (word_reg != '0 && emitted_reg < in_reg.limit)
                begin
                    if (out_free)
                    begin
                        out_next.kind        = kceq_pkg::KIND_HELD_CODE;
                        out_next.out_key     = kceq_pkg::KEY_W'({row_reg, low_idx});
                        out_next.out_pressed = 1'b0;
                        out_next.held_count  = '0;
                        out_next.dropped     = 1'b0;
                        out_next.pending     = !fifo_sts.empty;
                        out_next.wake        = wake_reg;
                        out_next.last        = 1'b0;
                        out_valid_next       = 1'b1;
                        word_next            = word_reg & (word_reg - 1'b1);
                        emitted_next         = emitted_reg + 1'b1;
                    end
                end
                else if (row_reg == ROW_LAST)
                begin
                    res_kind_next = kceq_pkg::KIND_HELD_CNT;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    row_next      = row_reg + 1'b1;
                    map_rd_row    = row_reg + 1'b1;
                    map_ctl.rd_en = 1'b1;
                    state_next    = ST_LIST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.kind        = res_kind_reg;
                    out_next.out_key     = res_key_reg;
                    out_next.out_pressed = res_pressed_reg;
                    out_next.held_count  = kceq_pkg::HCNT_W'(count_reg);
                    out_next.dropped     = res_dropped_reg;
                    out_next.pending     = !fifo_sts.empty;
                    out_next.wake        = wake_reg;
                    out_next.last        = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        in_reg          <= in_next;
        res_kind_reg    <= res_kind_next;
        res_key_reg     <= res_key_next;
        res_pressed_reg <= res_pressed_next;
        res_dropped_reg <= res_dropped_next;
        row_reg         <= row_next;
        word_reg        <= word_next;
        out_reg         <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            wake_reg      <= 1'b0;
            count_reg     <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            wake_reg      <= wake_next;
            count_reg     <= count_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // one command at a time
    `KCEQ_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    `KCEQ_ASSERT_NOW(a_fifo_sts_sane, clk, rst_n, fifo_sts.empty, !fifo_sts.full)
    `KCEQ_ASSERT_NOW(a_code_not_last, clk, rst_n,
        out_valid && out_data.kind == kceq_pkg::KIND_HELD_CODE, !out_data.last)
    // emptying pop drops wake
    `KCEQ_ASSERT_NOW(a_pop_empty_wake, clk, rst_n,
        out_valid && out_data.kind == kceq_pkg::KIND_POPPED && !out_data.pending,
        !out_data.wake)

endmodule

// ===== rtl/kceq_held_map.sv =====
// ----------------------------------------------------------------------------
// kceq_held_map
// Held-key bitmap: word memory with registered read and per-row valid bits.
// ----------------------------------------------------------------------------
module kceq_held_map #(
    parameter int  KEY_COUNT = kceq_pkg::KEY_COUNT_DEF,
    localparam int ROWS      = (KEY_COUNT + kceq_pkg::MAP_W - 1) / kceq_pkg::MAP_W,
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kceq_pkg::map_ctl_t           ctl,
    input  logic [ROW_W-1:0]             rd_row,
    input  logic [ROW_W-1:0]             wr_row,
    input  logic [kceq_pkg::MAP_W-1:0]   wr_data,
    output logic [kceq_pkg::MAP_W-1:0]   rd_data
);

    localparam int DEPTH = 1 << ROW_W;

    logic [kceq_pkg::MAP_W-1:0] map_mem [DEPTH];
    logic [kceq_pkg::MAP_W-1:0] rd_word_reg;
    logic                       rd_valid_reg;
    logic [DEPTH-1:0]           row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            map_mem[wr_row] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_word_reg <= map_mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
            if (ctl.clr_all)
            begin
                row_valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/kceq_event_fifo.sv =====
// ----------------------------------------------------------------------------
// kceq_event_fifo
// Key change event FIFO: circular memory with pointers and fill count.
// ----------------------------------------------------------------------------
module kceq_event_fifo #(
    parameter int QUEUE_DEPTH = kceq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kceq_pkg::fifo_ctl_t  ctl,
    input  kceq_pkg::event_t     push_data,
    output kceq_pkg::event_t     rd_data,
    output kceq_pkg::fifo_sts_t  sts
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    kceq_pkg::event_t   fifo_mem [QUEUE_DEPTH];
    kceq_pkg::event_t   rd_data_reg;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
        rd_data_reg <= fifo_mem[rd_ptr_reg];
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.flush)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    assign rd_data   = rd_data_reg;
    assign sts.empty = (fill_reg == '0);
    assign sts.full  = (fill_reg == FILL_FULL);
    assign sts.one   = (fill_reg == FILL_W'(1));

endmodule

// ===== tb/sv/key_change_event_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_change_event_queue_unit_tb
// Self-checking testbench for the key change event queue.
//
// A driver feeds command beats from a backlog, and a predictor updates its own
// copy of the held-key map, event FIFO, wake flag and enable bit for each
// accepted beat. A monitor compares every result beat against the oldest
// predicted one. Both sides stall at random, and the receiver holds off once
// for a long stretch so that the block backs up. The enable register is
// written between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module key_change_event_queue_unit_tb;

    localparam int          CLK_HALF      = 4;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          LONG_HOLD     = 400;
    localparam int          CYCLE_LIMIT   = 4000000;
    localparam logic [2:0]  MODE_UNUSED   = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_data  = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    kceq_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    kceq_pkg::out_t out_data;

    key_change_event_queue_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // predicted block state
    bit               m_held [kceq_pkg::KEY_COUNT_DEF];
    kceq_pkg::event_t m_events [$];
    bit               m_wake   = 1'b0;
    bit               m_enable = 1'b0;

    // held state as the command generator sees it
    bit     gen_held [kceq_pkg::KEY_COUNT_DEF];

    kceq_pkg::in_t  cmd_backlog [$];
    kceq_pkg::out_t awaited_results [$];

    int     err_count    = 0;
    int     cmds_taken   = 0;
    int     beats_seen   = 0;
    int     drops_seen   = 0;
    int     list_walks   = 0;
    int     max_held     = 0;
    int     cycle_count  = 0;
    int     send_gap     = 0;
    int     stall_left   = 0;
    bit     steady_flow  = 1'b0;
    bit     long_hold_go = 1'b0;
    bit     long_hold_done = 1'b0;

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (steady_flow || r < 60)
            return 0;
        else if (r < 92)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(10, 40));
    endfunction

    task automatic push_result(input kceq_pkg::out_t r, input bit fin);
        r.pending = (m_events.size() != 0);
        r.wake    = m_wake;
        r.last    = fin;
        awaited_results.push_back(r);
    endtask

    task automatic flush_events();
        m_events.delete();
        m_wake = 1'b0;
    endtask

    task automatic compute_key_results(input kceq_pkg::in_t cmd);
        kceq_pkg::out_t   r;
        kceq_pkg::event_t ev;
        int unsigned      cnt;
        bit               drop;
        r = '0;
        case (cmd.mode)
            kceq_pkg::MODE_KEY_EVENT, kceq_pkg::MODE_SYNTHESIZE:
            begin
                drop = 1'b0;
                if (cmd.key_code < kceq_pkg::KEY_COUNT_DEF &&
                    m_held[cmd.key_code] != cmd.press) begin
                    m_held[cmd.key_code] = cmd.press;
                    if (cmd.mode == kceq_pkg::MODE_SYNTHESIZE || m_enable) begin
                        if (m_events.size() >= kceq_pkg::QUEUE_DEPTH_DEF) begin
                            drop = 1'b1;
                            drops_seen++;
                        end
                        else begin
                            ev.key     = cmd.key_code[kceq_pkg::KEY_W-1:0];
                            ev.pressed = cmd.press;
                            m_events.push_back(ev);
                            m_wake = 1'b1;
                        end
                    end
                end
                r.kind    = kceq_pkg::KIND_ACK;
                r.dropped = drop;
                push_result(r, 1'b1);
            end
            kceq_pkg::MODE_POP:
            begin
                if (m_events.size() == 0) begin
                    r.kind = kceq_pkg::KIND_EMPTY;
                end
                else begin
                    ev = m_events.pop_front();
                    if (m_events.size() == 0)
                        m_wake = 1'b0;
                    r.kind        = kceq_pkg::KIND_POPPED;
                    r.out_key     = ev.key;
                    r.out_pressed = ev.pressed;
                end
                push_result(r, 1'b1);
            end
            kceq_pkg::MODE_LIST_HELD:
            begin
                cnt = 0;
                list_walks++;
                for (int i = 0; i < kceq_pkg::KEY_COUNT_DEF; i++) begin
                    if (m_held[i]) begin
                        if (cnt < cmd.limit) begin
                            r         = '0;
                            r.kind    = kceq_pkg::KIND_HELD_CODE;
                            r.out_key = i[kceq_pkg::KEY_W-1:0];
                            push_result(r, 1'b0);
                        end
                        cnt++;
                    end
                end
                if (cnt > max_held)
                    max_held = int'(cnt);
                r            = '0;
                r.kind       = kceq_pkg::KIND_HELD_CNT;
                r.held_count = cnt[kceq_pkg::HCNT_W-1:0];
                push_result(r, 1'b1);
            end
            kceq_pkg::MODE_CLEAR_EVENTS:
            begin
                flush_events();
                r.kind = kceq_pkg::KIND_ACK;
                push_result(r, 1'b1);
            end
            kceq_pkg::MODE_RESET_ALL, kceq_pkg::MODE_FOCUS_LOST:
            begin
                flush_events();
                foreach (m_held[i])
                    m_held[i] = 1'b0;
                if (cmd.mode == kceq_pkg::MODE_FOCUS_LOST)
                    m_wake = m_enable;
                r.kind = kceq_pkg::KIND_ACK;
                push_result(r, 1'b1);
            end
            default:
            begin
                r.kind = kceq_pkg::KIND_ACK;
                push_result(r, 1'b1);
            end
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            err_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin : drv
        bit took;
        took = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (took) begin
                compute_key_results(in_data);
                cmds_taken++;
            end
            if (!in_valid || took) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (cmd_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_backlog.pop_front();
                    send_gap <= pick_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge clk)
    begin : rcv
        int n;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (long_hold_go && !long_hold_done) begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD;
            out_stall      <= 1'b1;
        end
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else begin
            n = pick_gap();
            out_stall  <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : mon
        kceq_pkg::out_t want;
        if (rst_n && out_valid && !out_stall) begin
            beats_seen++;
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d key %0d",
                       out_data.kind, out_data.out_key);
                err_count++;
            end
            else begin
                want = awaited_results.pop_front();
                cmp_field("kind",        16'(want.kind),        16'(out_data.kind));
                cmp_field("out_key",     16'(want.out_key),     16'(out_data.out_key));
                cmp_field("out_pressed", 16'(want.out_pressed), 16'(out_data.out_pressed));
                cmp_field("held_count",  16'(want.held_count),  16'(out_data.held_count));
                cmp_field("dropped",     16'(want.dropped),     16'(out_data.dropped));
                cmp_field("pending",     16'(want.pending),     16'(out_data.pending));
                cmp_field("wake",        16'(want.wake),        16'(out_data.wake));
                cmp_field("last",        16'(want.last),        16'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d beats still expected", awaited_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] mode, input logic [15:0] code,
                           input logic press, input logic [5:0] lim);
        kceq_pkg::in_t c;
        c.mode     = mode;
        c.key_code = code;
        c.press    = press;
        c.limit    = lim;
        cmd_backlog.push_back(c);
        if ((mode == kceq_pkg::MODE_KEY_EVENT || mode == kceq_pkg::MODE_SYNTHESIZE) &&
            code < kceq_pkg::KEY_COUNT_DEF)
            gen_held[code] = press;
        if (mode == kceq_pkg::MODE_RESET_ALL || mode == kceq_pkg::MODE_FOCUS_LOST)
            foreach (gen_held[i])
                gen_held[i] = 1'b0;
    endtask

    function automatic int pick_key();
        int r;
        r = int'($urandom_range(0, 3));
        if (r < 2)
            return int'($urandom_range(0, 31));
        else if (r == 2)
            return int'($urandom_range(1000, kceq_pkg::KEY_COUNT_DEF - 1));
        else
            return int'($urandom_range(0, kceq_pkg::KEY_COUNT_DEF - 1));
    endfunction

    task automatic add_random_cmd();
        int         r;
        int         k;
        logic       p;
        logic [2:0] md;
        logic [5:0] lim;
        r  = int'($urandom_range(0, 99));
        k  = pick_key();
        p  = ($urandom_range(0, 9) == 0) ? logic'($urandom_range(0, 1)) : !gen_held[k];
        md = ($urandom_range(0, 1) == 0) ? kceq_pkg::MODE_KEY_EVENT
                                         : kceq_pkg::MODE_SYNTHESIZE;
        if (r < 36)
            add_cmd(kceq_pkg::MODE_KEY_EVENT, 16'(k), p, 6'($urandom_range(0, 63)));
        else if (r < 56)
            add_cmd(kceq_pkg::MODE_SYNTHESIZE, 16'(k), p, 6'($urandom_range(0, 63)));
        else if (r < 76)
            add_cmd(kceq_pkg::MODE_POP, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (r < 84) begin
            lim = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 6));
            if ($urandom_range(0, 9) == 0)
                lim = 6'd63;
            add_cmd(kceq_pkg::MODE_LIST_HELD, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), lim);
        end
        else if (r < 89)
            add_cmd(md, 16'($urandom_range(kceq_pkg::KEY_COUNT_DEF, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (r < 92)
            add_cmd(kceq_pkg::MODE_CLEAR_EVENTS, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (r < 94)
            add_cmd(kceq_pkg::MODE_RESET_ALL, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (r < 96)
            add_cmd(kceq_pkg::MODE_FOCUS_LOST, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else
            add_cmd(MODE_UNUSED, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        m_enable = v;
        if (!v)
            flush_events();
    endtask

    initial
    begin
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // disabled: device events only touch the map, synthesized ones queue
        write_enable(1'b0);
        add_cmd(kceq_pkg::MODE_POP,          16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd0,     1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd1023,  1'b1, 6'd63);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd1024,  1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_SYNTHESIZE,   16'hFFFF,  1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd0,     1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_SYNTHESIZE,   16'd5,     1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_LIST_HELD,    16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_LIST_HELD,    16'hFFFF,  1'b1, 6'd63);
        add_cmd(kceq_pkg::MODE_LIST_HELD,    16'd0,     1'b0, 6'd1);
        add_cmd(kceq_pkg::MODE_POP,          16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_POP,          16'd0,     1'b0, 6'd0);
        add_cmd(MODE_UNUSED,                 16'hA5A5,  1'b1, 6'd42);
        add_cmd(kceq_pkg::MODE_FOCUS_LOST,   16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_LIST_HELD,    16'd0,     1'b0, 6'd2);
        wait_idle();

        write_enable(1'b1);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd3,     1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_KEY_EVENT,    16'd3,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_POP,          16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_CLEAR_EVENTS, 16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_SYNTHESIZE,   16'd10,    1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_RESET_ALL,    16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_SYNTHESIZE,   16'd20,    1'b1, 6'd0);
        add_cmd(kceq_pkg::MODE_FOCUS_LOST,   16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_POP,          16'd0,     1'b0, 6'd0);
        add_cmd(kceq_pkg::MODE_LIST_HELD,    16'd0,     1'b0, 6'd5);
        wait_idle();

        // receiver holds off while commands keep coming
        long_hold_go <= 1'b1;
        repeat (70) add_random_cmd();
        wait_idle();

        // overfill the FIFO, then drain part of it
        add_cmd(kceq_pkg::MODE_CLEAR_EVENTS, 16'd0, 1'b0, 6'd0);
        for (int i = 0; i < kceq_pkg::QUEUE_DEPTH_DEF + 4; i++) begin
            k = 100 + i;
            add_cmd((i % 2 == 0) ? kceq_pkg::MODE_KEY_EVENT : kceq_pkg::MODE_SYNTHESIZE,
                    16'(k), !gen_held[k], 6'd0);
        end
        add_cmd(kceq_pkg::MODE_LIST_HELD, 16'd0, 1'b0, 6'd63);
        repeat (10) add_cmd(kceq_pkg::MODE_POP, 16'($urandom_range(0, 65535)), 1'b0, 6'd0);
        wait_idle();

        // disabling with events still queued flushes them
        write_enable(1'b0);
        repeat (30) add_random_cmd();
        wait_idle();

        write_enable(1'b1);
        steady_flow <= 1'b1;
        repeat (30) add_random_cmd();
        wait_idle();
        steady_flow <= 1'b0;

        if (awaited_results.size() != 0) begin
            $error("%0d expected result beats never arrived", awaited_results.size());
            err_count++;
        end
        $display("Run covered %0d commands and %0d result beats, %0d held-key walks",
                 cmds_taken, beats_seen, list_walks);
        $display("Dropped events on full FIFO: %0d, most keys held at once: %0d",
                 drops_seen, max_held);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kceq_pkg.sv
rtl/kceq_held_map.sv
rtl/kceq_event_fifo.sv
rtl/key_change_event_queue_unit.sv
tb/sv/key_change_event_queue_unit_tb.sv
